// File: hw/rtl/dssd_pkg.sv
// Shared types, constants and the segment decoder of the scan display.
package dssd_pkg;

  localparam int DIGIT_COUNT_DEF = 8;
  localparam int VALUE_W         = 31;
  localparam int POS_OUT_W       = 3;
  localparam int SEG_W           = 8;
  localparam int BIN_STEPS       = VALUE_W;
  localparam int STEP_W          = $clog2(BIN_STEPS);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_BAD   = 8'h76;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic tick;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
  } status_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h67;
      default: s = SEG_BAD;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/dssd_ifs.sv
// Valid/ready channel interfaces for the input items and the scan results.
interface dssd_in_if
  import dssd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface dssd_out_if
  import dssd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] digit_position;
  logic [SEG_W-1:0]     segment_pattern;

  modport source (output valid, output digit_position, output segment_pattern, input ready);
  modport sink   (input valid, input digit_position, input segment_pattern, output ready);
endinterface

// File: hw/rtl/dssd_ctrl.sv
// Controller: handshakes, load sequencing and result valid.
module dssd_ctrl
  import dssd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CONV   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load   = accept && (in_op == OP_LOAD);
    cmd.tick   = accept && (in_op == OP_TICK);
    cmd.step   = (state_r == S_CONV);
    cmd.commit = (state_r == S_COMMIT);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (cmd.load) state_nxt = S_CONV;
      S_CONV:   if (sts.conv_done) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.tick) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/dssd_dp.sv
// Datapath: shift-add-3 BCD converter, pattern store, scan counter, result register.
module dssd_dp
  import dssd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic [VALUE_W-1:0]   in_value,
  output logic [POS_OUT_W-1:0] out_pos,
  output logic [SEG_W-1:0]     out_seg
);

  localparam int PW    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int BCD_W = 4 * DIGIT_COUNT;

  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [SEG_W-1:0]     pat_r   [DIGIT_COUNT];
  logic [SEG_W-1:0]     pat_nxt [DIGIT_COUNT];
  logic [PW-1:0]        scan_r, scan_nxt;
  logic [PW+2:0]        scan_ext;
  logic [POS_OUT_W-1:0] pos_r, pos_nxt;
  logic [SEG_W-1:0]     seg_r, seg_nxt;

  assign sts.conv_done = (cnt_r == STEP_W'(BIN_STEPS - 1));

  always_comb begin
    for (int j = 0; j < DIGIT_COUNT; j++) begin
      bcd_adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? bcd_r[4*j +: 4] + 4'd3
                                                     : bcd_r[4*j +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.step) begin
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      cnt_nxt = cnt_r + STEP_W'(1);
    end
  end

  // Position 0 is the most significant digit.
  always_comb begin
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      pat_nxt[k] = cmd.commit ? seg_of(bcd_r[4*(DIGIT_COUNT-1-k) +: 4]) : pat_r[k];
    end
  end

  assign scan_ext = {3'b000, scan_r};

  always_comb begin
    scan_nxt = scan_r;
    pos_nxt  = pos_r;
    seg_nxt  = seg_r;
    if (cmd.tick) begin
      pos_nxt  = scan_ext[POS_OUT_W-1:0];
      seg_nxt  = pat_r[scan_r];
      scan_nxt = (scan_r == PW'(DIGIT_COUNT - 1)) ? '0 : scan_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      for (int k = 0; k < DIGIT_COUNT; k++) pat_r[k] <= SEG_BLANK;
    end else begin
      scan_r <= scan_nxt;
      for (int k = 0; k < DIGIT_COUNT; k++) pat_r[k] <= pat_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    seg_r <= seg_nxt;
  end

  assign out_pos = pos_r;
  assign out_seg = seg_r;

endmodule

// File: hw/rtl/decimal_seven_segment_scan_display.sv
// Multiplexed seven-segment decimal display: a load transaction converts a
// 31-bit binary value to its DIGIT_COUNT lowest decimal digits (higher digits
// wrap away) and stores one segment pattern per digit, leftmost digit at
// position 0; no new item is accepted until the load is through (the accept,
// 31 shift-add-3 steps of the BCD converter, then one pattern write), and it
// returns no result. On a tick transaction, the pattern and position of the
// current scan slot appear in the output register on the next cycle, and the
// scan position advances modulo DIGIT_COUNT. Ticks may be accepted back to
// back as long as the output register is drained. All digits read blank
// until the first load.
module decimal_seven_segment_scan_display
  import dssd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dssd_in_if.sink   in_ch,
  dssd_out_if.source out_ch
);

  cmd_t    cmd;
  status_t sts;

  dssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dssd_dp #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_value (in_ch.value),
    .out_pos  (out_ch.digit_position),
    .out_seg  (out_ch.segment_pattern)
  );

`ifndef SYNTH
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |=> out_ch.valid)
    else $error("tick transaction produced no result");

  a_conv_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.conv_done) |=> cmd.commit)
    else $error("conversion end not followed by pattern write");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (!cmd.commit && !cmd.step))
    else $error("pattern write not followed by idle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.commit) |-> !in_ch.ready)
    else $error("input ready during load conversion");
`endif

endmodule

// File: test/dssd_scan_checker.sv
// Checker for the scan display: predicts every tick result and compares it with the output channel.
`timescale 1ns / 1ps

module dssd_scan_checker
  import dssd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dssd_in_if   in_ch,
  dssd_out_if  out_ch,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [POS_OUT_W-1:0] pos;
    logic [SEG_W-1:0]     seg;
  } scan_result_t;

  logic [SEG_W-1:0] glyph_of_digit [10];
  logic [SEG_W-1:0] shown_glyphs [DIGIT_COUNT_DEF];
  int unsigned      scan_slot;
  scan_result_t     scan_expect [$];

  initial begin
    glyph_of_digit = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h67};
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Lowest decimal digits go right to left; higher digits wrap away.
  task automatic load_display(input logic [VALUE_W-1:0] v);
    int unsigned rest;
    rest = {1'b0, v};
    for (int k = DIGIT_COUNT_DEF - 1; k >= 0; k--) begin
      shown_glyphs[k] = glyph_of_digit[rest % 10];
      rest = rest / 10;
    end
  endtask

  task automatic predict_tick();
    scan_result_t r;
    if (scan_slot >= DIGIT_COUNT_DEF) begin
      scan_slot = 0;
    end
    r.pos = scan_slot[POS_OUT_W-1:0];
    r.seg = shown_glyphs[scan_slot];
    scan_expect.push_back(r);
    scan_slot = (scan_slot + 1) % DIGIT_COUNT_DEF;
  endtask

  always @(posedge clk) begin : watch
    scan_result_t got;
    scan_result_t want;
    if (!rst_n) begin
      foreach (shown_glyphs[k]) shown_glyphs[k] = SEG_BLANK;
      scan_slot = 0;
      scan_expect.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_LOAD) begin
          load_display(in_ch.value);
        end else begin
          predict_tick();
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got.pos = out_ch.digit_position;
        got.seg = out_ch.segment_pattern;
        if (scan_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result pos=%0d seg=%02h", got.pos, got.seg));
        end else begin
          want = scan_expect.pop_front();
          if (got.pos !== want.pos) begin
            report_mismatch($sformatf("digit_position %0d, expected %0d", got.pos, want.pos));
          end
          if (got.seg !== want.seg) begin
            report_mismatch($sformatf("segment_pattern %02h, expected %02h at pos %0d",
                                      got.seg, want.seg, want.pos));
          end
        end
      end
    end
    outstanding = scan_expect.size();
  end

endmodule

// File: test/decimal_seven_segment_scan_display_tb.sv
// Top of the scan display testbench: clock, reset, load and tick stimulus, verdict.
`timescale 1ns / 1ps

module decimal_seven_segment_scan_display_tb;
  import dssd_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   mismatches;
  int   outstanding;

  dssd_in_if  in_ch ();
  dssd_out_if out_ch ();

  decimal_seven_segment_scan_display DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dssd_scan_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  assign out_ch.ready = sink_ready;

  always @(posedge clk) begin
    sink_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // One transaction on the input channel; returns at the accepting edge.
  task automatic issue_op(input logic op, input logic [VALUE_W-1:0] val);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned      p10;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = VALUE_W'($urandom_range(0, 999));
      1: begin
        p10 = 1;
        repeat ($urandom_range(1, 9)) p10 = p10 * 10;
        v = VALUE_W'(p10 - 1 + $urandom_range(0, 2));
      end
      2: v = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 5));
      default: v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  // Mostly a load followed by a run of ticks; some lone ticks as noise.
  task automatic run_traffic(input int src_idle, input int snk_idle, input int items);
    int sent;
    int burst;
    in_idle_pct  = src_idle;
    out_idle_pct = snk_idle;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        issue_op(OP_TICK, VALUE_W'($urandom));
        sent++;
      end
      issue_op(OP_LOAD, pick_value());
      sent++;
      burst = $urandom_range(0, 12);
      repeat (burst) begin
        issue_op(OP_TICK, VALUE_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_LOAD;
    in_ch.value = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // blank display before any load, then load keeps the scan position
    repeat (3) issue_op(OP_TICK, '0);
    issue_op(OP_LOAD, 31'd12345678);
    repeat (6) issue_op(OP_TICK, {VALUE_W{1'b1}});
    issue_op(OP_LOAD, {VALUE_W{1'b1}});
    repeat (2) issue_op(OP_TICK, '0);
    issue_op(OP_LOAD, 31'd100000000);
    issue_op(OP_TICK, '0);
    issue_op(OP_LOAD, 31'd99999999);
    issue_op(OP_TICK, '0);
    issue_op(OP_LOAD, 31'h5555_5555);
    issue_op(OP_TICK, '0);
    issue_op(OP_LOAD, 31'd1);
    issue_op(OP_TICK, '0);
    drain_results();

    run_traffic(9, 75, 600);
    drain_results();
    run_traffic(75, 9, 600);
    drain_results();
    run_traffic(0, 0, 600);
    drain_results();
    repeat (40) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
